// ===== rtl/lif_pkg.sv =====
// Shared types, widths and constants for the LIF neuron RK4 update unit.
package lif_pkg;

    // Field widths
    localparam int IDX_W    = 10;
    localparam int VOLT_W   = 16;
    localparam int CNT_W    = 8;
    localparam int TIME_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    // Datapath widths
    localparam int D_W    = 28;   // stage operand (2^-16 volt units)
    localparam int G_W    = 23;   // second multiplier operand
    localparam int PROD_W = 51;   // shared multiplier product
    localparam int K_W    = 29;   // RK4 stage slope
    localparam int S_W    = 32;   // weighted slope sum
    localparam int U_W    = 21;   // biased quotient input of the divide by three
    localparam int Q_W    = 22;   // signed voltage increment
    localparam int NV_W   = 23;   // unsaturated new voltage

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_VOLTAGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd1638;
    localparam logic signed [VOLT_W-1:0] VRST_RESET = 16'sd0;
    localparam logic signed [VOLT_W-1:0] THR_RESET  = 16'sd3840;

    // Voltage constants, Q8.8
    localparam logic signed [VOLT_W-1:0] VOLT_RESET_LIMIT = 16'sd5120;  // 20.0
    localparam logic signed [VOLT_W-1:0] VOLT_SPIKE       = 16'sd7680;  // 30.0
    localparam logic signed [VOLT_W-1:0] VOLT_MAX         = 16'sd32767;
    localparam logic signed [VOLT_W-1:0] VOLT_MIN         = -16'sd32768;
    localparam logic [CNT_W-1:0]         CNT_MAX          = 8'd255;

    // Divide by 1536: bias by 768 for rounding, plus 3*2^19 quotient offset
    // shifted up by 9 so the dividend stays positive.
    localparam logic signed [S_W-1:0]  DIV_BIAS   = 32'sd805307136;
    localparam logic signed [G_W-1:0]  RECIP3     = 23'sd2796202;   // floor(2^23/3)
    localparam int                     RECIP3_SH  = 23;
    localparam logic signed [Q_W-1:0]  Q_OFFSET   = 22'sd524288;    // 2^19
    localparam logic signed [PROD_W-1:0] K_ROUND  = 51'sd32768;

    // Controller states
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_ACC   = 9'b000010000,
        ST_DIVA  = 9'b000100000,
        ST_DIVB  = 9'b001000000,
        ST_CORR  = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic load;
        logic mul;
        logic acc;
        logic div_a;
        logic div_b;
        logic corr;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic last_stage;
        logic out_free;
    } status_t;

    // True when a nibble digit sum is a multiple of five
    function automatic logic is_mult5(input logic [5:0] x);
        logic hit;
        case (x) inside
            6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30,
            6'd35, 6'd40, 6'd45, 6'd50, 6'd55, 6'd60: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/lif_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lif_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lif_ctrl.sv =====
// Sequencer for one neuron update: clear pass, load, RK4 stages, divide, write back.
module lif_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lif_pkg::status_t  status,
    output lif_pkg::cmd_t     cmd
);

    lif_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lif_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the step sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lif_pkg::ST_CLEAR: if (status.clear_done) state_next = lif_pkg::ST_IDLE;
            lif_pkg::ST_IDLE:  if (s_tvalid) state_next = lif_pkg::ST_LOAD;
            lif_pkg::ST_LOAD:  state_next = lif_pkg::ST_MUL;
            lif_pkg::ST_MUL:   state_next = lif_pkg::ST_ACC;
            lif_pkg::ST_ACC: begin
                state_next = status.last_stage ? lif_pkg::ST_DIVA : lif_pkg::ST_MUL;
            end
            lif_pkg::ST_DIVA:  state_next = lif_pkg::ST_DIVB;
            lif_pkg::ST_DIVB:  state_next = lif_pkg::ST_CORR;
            lif_pkg::ST_CORR:  state_next = lif_pkg::ST_FIN;
            lif_pkg::ST_FIN:   if (status.out_free) state_next = lif_pkg::ST_IDLE;
            default:           state_next = lif_pkg::ST_CLEAR;
        endcase
    end

    // Decode commands
    assign s_tready    = (state_reg == lif_pkg::ST_IDLE);
    assign cmd.clear   = (state_reg == lif_pkg::ST_CLEAR);
    assign cmd.capture = (state_reg == lif_pkg::ST_IDLE) && s_tvalid;
    assign cmd.load    = (state_reg == lif_pkg::ST_LOAD);
    assign cmd.mul     = (state_reg == lif_pkg::ST_MUL);
    assign cmd.acc     = (state_reg == lif_pkg::ST_ACC);
    assign cmd.div_a   = (state_reg == lif_pkg::ST_DIVA);
    assign cmd.div_b   = (state_reg == lif_pkg::ST_DIVB);
    assign cmd.corr    = (state_reg == lif_pkg::ST_CORR);
    assign cmd.finish  = (state_reg == lif_pkg::ST_FIN) && status.out_free;

    // Results are only committed into a free output register
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result committed while output register busy");

    // No beat is taken before the clearing pass has finished
    a_accept_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> status.clear_done)
        else $error("input beat accepted during clearing pass");

    // The fourth stage hands over to the divide
    a_last_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && status.last_stage) |=> cmd.div_a)
        else $error("divide did not follow the last RK4 stage");

endmodule

// ===== rtl/lif_dp.sv =====
// Datapath: config registers, neuron state RAM, shared multiplier, RK4 and output register.
module lif_dp #(
    parameter int NEURON_COUNT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lif_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lif_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [lif_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [lif_pkg::M_DATA_W-1:0]       m_tdata,
    input  lif_pkg::cmd_t                      cmd,
    output lif_pkg::status_t                   status
);

    localparam int ADDR_W = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int VOLT_W = lif_pkg::VOLT_W;
    localparam int CNT_W  = lif_pkg::CNT_W;
    localparam int WORD_W = VOLT_W + CNT_W;
    localparam int IDX_W  = lif_pkg::IDX_W;
    localparam int D_W    = lif_pkg::D_W;
    localparam int G_W    = lif_pkg::G_W;
    localparam int PROD_W = lif_pkg::PROD_W;
    localparam int K_W    = lif_pkg::K_W;
    localparam int S_W    = lif_pkg::S_W;
    localparam int U_W    = lif_pkg::U_W;
    localparam int Q_W    = lif_pkg::Q_W;
    localparam int NV_W   = lif_pkg::NV_W;

    // Configuration registers
    logic [lif_pkg::GAIN_W-1:0] gain_reg;
    logic signed [VOLT_W-1:0]   vrst_reg;
    logic signed [VOLT_W-1:0]   thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= lif_pkg::GAIN_RESET;
            vrst_reg <= lif_pkg::VRST_RESET;
            thr_reg  <= lif_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lif_pkg::CFG_STEP_GAIN:       gain_reg <= cfg_wdata;
                lif_pkg::CFG_RESET_VOLTAGE:   vrst_reg <= cfg_wdata;
                lif_pkg::CFG_SPIKE_THRESHOLD: thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input beat fields
    logic [IDX_W-1:0]            in_idx;
    logic signed [VOLT_W-1:0]    in_cur;
    logic [lif_pkg::TIME_W-1:0]  in_time;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_cur  = s_tdata[IDX_W +: VOLT_W];
    assign in_time = s_tdata[IDX_W + VOLT_W +: lif_pkg::TIME_W];

    logic [IDX_W-1:0]            idx_reg;
    logic signed [VOLT_W-1:0]    cur_reg;
    logic [lif_pkg::TIME_W-1:0]  time_reg;
    logic                        idx_ok_reg;

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg    <= in_idx;
            cur_reg    <= in_cur;
            time_reg   <= in_time;
            idx_ok_reg <= (32'(in_idx) < 32'(NEURON_COUNT));
        end
    end

    // Clearing pass after reset
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clear && !clr_done_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NEURON_COUNT - 1)) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // Neuron state RAM: voltage in the upper bits, window counter in the lower
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic signed [VOLT_W-1:0] nv_final;
    logic [CNT_W-1:0]         cnt_out;
    logic                     wclr_reg;

    assign ram_we    = (cmd.clear && !clr_done_reg) || (cmd.finish && idx_ok_reg);
    assign ram_waddr = cmd.clear ? clr_addr_reg : ADDR_W'(idx_reg);
    assign ram_wdata = cmd.clear ? '0 : {nv_final, (wclr_reg ? {CNT_W{1'b0}} : cnt_out)};

    lif_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NEURON_COUNT)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ADDR_W'(in_idx)),
        .rdata (ram_rdata)
    );

    // Load the old state and scale to 2^-16 volt
    logic signed [VOLT_W-1:0] v_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [VOLT_W-1:0] v_load;
    logic [5:0]               nib_sum;
    logic signed [D_W-1:0]    v_scaled;
    logic signed [D_W-1:0]    i_scaled;
    logic signed [D_W-1:0]    v_load_scaled;

    assign v_load  = idx_ok_reg ? ram_rdata[CNT_W +: VOLT_W] : vrst_reg;
    assign nib_sum = 6'(time_reg[3:0]) + 6'(time_reg[7:4])
                   + 6'(time_reg[11:8]) + 6'(time_reg[15:12]);
    assign v_scaled      = {{(D_W-VOLT_W-8){v_reg[VOLT_W-1]}}, v_reg, 8'd0};
    assign i_scaled      = {{(D_W-VOLT_W-8){cur_reg[VOLT_W-1]}}, cur_reg, 8'd0};
    assign v_load_scaled = {{(D_W-VOLT_W-8){v_load[VOLT_W-1]}}, v_load, 8'd0};

    // Shared multiplier: stage slope or reciprocal of three
    logic signed [D_W-1:0]    x_reg, x_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [D_W-1:0]    mul_a;
    logic signed [G_W-1:0]    mul_b;
    logic [U_W-1:0]           u_reg;

    assign mul_a     = cmd.div_b ? {{(D_W-U_W){1'b0}}, u_reg} : (i_scaled - x_reg);
    assign mul_b     = cmd.div_b ? lif_pkg::RECIP3
                                 : {{(G_W-lif_pkg::GAIN_W){1'b0}}, gain_reg};
    assign prod_next = mul_a * mul_b;

    // Stage slope, rounded half up
    logic signed [PROD_W-1:0] k_full;
    logic signed [K_W-1:0]    k_val;
    logic signed [K_W-1:0]    k_half;
    logic signed [S_W-1:0]    k_ext;
    logic [1:0]               stage_reg;
    logic signed [S_W-1:0]    s_reg, s_next;

    assign k_full = (prod_reg + lif_pkg::K_ROUND) >>> 16;
    assign k_val  = k_full[K_W-1:0];
    assign k_half = k_val >>> 1;
    assign k_ext  = {{(S_W-K_W){k_val[K_W-1]}}, k_val};
    assign s_next = (stage_reg == 2'd1 || stage_reg == 2'd2)
                  ? s_reg + (k_ext <<< 1) : s_reg + k_ext;
    assign x_next = (stage_reg == 2'd2) ? v_scaled + k_val[D_W-1:0]
                                        : v_scaled + k_half[D_W-1:0];

    // Divide by 1536 via biased shift and reciprocal multiply with one correction
    logic signed [S_W-1:0] div_sum;
    logic [U_W-1:0]        q_est;
    logic [U_W+1:0]        q_rem;
    logic [U_W-1:0]        q_fix;
    logic signed [Q_W-1:0] q_reg;

    assign div_sum = s_reg + lif_pkg::DIV_BIAS;
    assign q_est   = prod_reg[lif_pkg::RECIP3_SH +: U_W];
    assign q_rem   = {2'b00, u_reg} - ({2'b00, q_est} + {1'b0, q_est, 1'b0});
    assign q_fix   = q_est + U_W'(q_rem >= (U_W+2)'(3));

    // Sequence the arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg     <= v_load;
            cnt_reg   <= idx_ok_reg ? ram_rdata[CNT_W-1:0] : {CNT_W{1'b0}};
            x_reg     <= v_load_scaled;
            s_reg     <= '0;
            stage_reg <= 2'd0;
            wclr_reg  <= !time_reg[0] && lif_pkg::is_mult5(nib_sum);
        end
        if (cmd.mul || cmd.div_b) begin
            prod_reg <= prod_next;
        end
        if (cmd.acc) begin
            s_reg     <= s_next;
            x_reg     <= x_next;
            stage_reg <= stage_reg + 2'd1;
        end
        if (cmd.div_a) begin
            u_reg <= div_sum[9 +: U_W];
        end
        if (cmd.corr) begin
            q_reg <= $signed({1'b0, q_fix}) - lif_pkg::Q_OFFSET;
        end
    end

    // Saturate, apply reset limit and spike rule
    logic signed [NV_W-1:0]   nv_wide;
    logic signed [VOLT_W-1:0] nv_sat;
    logic signed [VOLT_W-1:0] nv_lim;
    logic                     spike;

    assign nv_wide = {{(NV_W-VOLT_W){v_reg[VOLT_W-1]}}, v_reg}
                   + {{(NV_W-Q_W){q_reg[Q_W-1]}}, q_reg};

    always_comb begin
        if (nv_wide > $signed({{(NV_W-VOLT_W){1'b0}}, lif_pkg::VOLT_MAX})) begin
            nv_sat = lif_pkg::VOLT_MAX;
        end else if (nv_wide < $signed({{(NV_W-VOLT_W){1'b1}}, lif_pkg::VOLT_MIN})) begin
            nv_sat = lif_pkg::VOLT_MIN;
        end else begin
            nv_sat = nv_wide[VOLT_W-1:0];
        end
    end

    assign nv_lim   = (nv_sat >= lif_pkg::VOLT_RESET_LIMIT) ? vrst_reg : nv_sat;
    assign spike    = (nv_lim > thr_reg);
    assign nv_final = spike ? lif_pkg::VOLT_SPIKE : nv_lim;
    assign cnt_out  = (spike && cnt_reg != lif_pkg::CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // Output register
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_idx_reg;
    logic                     m_fired_reg;
    logic [CNT_W-1:0]         m_cnt_reg;
    logic signed [VOLT_W-1:0] m_volt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_idx_reg   <= idx_reg;
            m_fired_reg <= spike;
            m_cnt_reg   <= cnt_out;
            m_volt_reg  <= nv_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lif_pkg::M_DATA_W-IDX_W-1-CNT_W-VOLT_W){1'b0}},
                       m_volt_reg, m_cnt_reg, m_fired_reg, m_idx_reg};

    assign status.clear_done = clr_done_reg;
    assign status.last_stage = (stage_reg == 2'd3);
    assign status.out_free   = !m_valid_reg || m_tready;

    // A spike always reports the spike voltage
    a_spike_volt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fired_reg) |-> (m_volt_reg == lif_pkg::VOLT_SPIKE))
        else $error("fired beat without spike voltage");

    // Write back only for neurons that exist
    a_wb_valid_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && !cmd.clear) |-> idx_ok_reg)
        else $error("state written for an out-of-range neuron");

endmodule

// ===== rtl/lif_neuron_rk4_update_unit.sv =====
// Top level of the LIF neuron RK4 update unit: controller plus datapath.
//
//  Channel   Direction  Payload (low bit first)
//  s_        in         neuron_index[9:0], input_current[25:10], time_whole[41:26]
//  m_        out        result_index[9:0], fired[10], spike_count[18:11],
//                       new_voltage[34:19]
//  cfg_      in         0 step_gain, 1 reset_voltage, 2 spike_threshold
//
// Each accepted beat runs a load (the RAM read happens at the accepting edge), four
// multiply/accumulate pairs through the single shared multiplier, then the divide by
// 1536 (DIVA, DIVB, CORR) and a finish step that commits the result. A new beat is
// accepted only in the idle state, so none is taken while one is still in progress.
// After reset a clearing pass writes zeros through the whole state RAM; s_tready
// stays low during it, while configuration writes are taken.
// A stalled result holds the unit in its final cycle until m_tready frees the
// output register; the next beat is accepted while a result waits.
module lif_neuron_rk4_update_unit #(
    parameter int NEURON_COUNT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lif_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // neuron_index, input_current, time_whole, zero pad
    input  logic [lif_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_index, fired, spike_count, new_voltage, zero pad
    output logic [lif_pkg::M_DATA_W-1:0]      m_tdata
);

    lif_pkg::cmd_t    cmd;
    lif_pkg::status_t status;

    lif_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lif_dp #(
        .NEURON_COUNT (NEURON_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
